>>> src/modbus_style_frame_receiver_macros.svh
// -----------------------------------------------------------------------------
// modbus_style_frame_receiver_macros.svh
// assertion shorthands shared by the frame receiver modules
// -----------------------------------------------------------------------------
`ifndef MODBUS_STYLE_FRAME_RECEIVER_MACROS_SVH
`define MODBUS_STYLE_FRAME_RECEIVER_MACROS_SVH

// same-cycle check, clocked on i_clk, off while i_rst_n is low
`define MSFR_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, clocked on i_clk, off while i_rst_n is low
`define MSFR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/msfr_pkg.sv
// -----------------------------------------------------------------------------
// msfr_pkg
// shared types, event codes and the crc-16 byte update
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msfr_pkg;

    // largest frame buffer the parser is sized for
    localparam int MAX_FRAME = 256;
    // a frame holds at most this many bytes (position must stay below it)
    localparam int FRAME_CAP = (MAX_FRAME < 255) ? MAX_FRAME : 255;

    localparam logic [7:0]  RESET_STATION = 8'h01;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    // function codes
    localparam logic [7:0] FC_READ     = 8'h04;
    localparam logic [7:0] FC_WRITE    = 8'h10;
    localparam logic [7:0] FC_EXCEPT   = 8'h90;
    localparam logic [7:0] FC_SET_ADDR = 8'h07;

    // result event codes
    localparam logic [2:0] EV_PROGRESS     = 3'd0;
    localparam logic [2:0] EV_OK           = 3'd1;
    localparam logic [2:0] EV_ADDR_CHANGED = 3'd2;
    localparam logic [2:0] EV_CRC_BAD      = 3'd3;
    localparam logic [2:0] EV_LEARNED      = 3'd4;
    localparam logic [2:0] EV_DISCARDED    = 3'd5;
    localparam logic [2:0] EV_OVERFLOW     = 3'd6;

    typedef struct packed {
        logic [2:0] event_res;
        logic       byte_stored;
        logic [7:0] byte_position;
        logic [7:0] byte_value;
        logic [7:0] frame_length;
        logic       turnaround;
        logic [7:0] station_address;
    } t_result;

    // modbus crc-16, reflected, one byte per call
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> src/msfr_parser.sv
// -----------------------------------------------------------------------------
// msfr_parser
// frame parse state, crc check and per-byte result decode
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modbus_style_frame_receiver_macros.svh"

module msfr_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_accept,
    input  logic [7:0]         i_rx_byte,
    output msfr_pkg::t_result  o_result
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FUNC   = 9'b000000010,
        S_THIRD  = 9'b000000100,
        S_B3     = 9'b000001000,
        S_B4     = 9'b000010000,
        S_B5     = 9'b000100000,
        S_CRC_LO = 9'b001000000,
        S_CRC_HI = 9'b010000000,
        S_COUNT  = 9'b100000000
    } t_step;

    t_step       r_step,      n_step;
    logic [7:0]  r_position,  n_position;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_func,      n_func;
    logic [7:0]  r_third,     n_third;
    logic [15:0] r_crc,       n_crc;
    logic [7:0]  r_crc_lo,    n_crc_lo;
    logic [7:0]  r_station,   n_station;
    logic        r_learned,   n_learned;

    logic        store;
    logic        go_idle;
    logic        complete;
    logic [15:0] crc_base;
    logic [15:0] crc_next;
    logic [15:0] crc_got;

    assign crc_base = (r_step == S_IDLE) ? msfr_pkg::CRC_INIT : r_crc;
    assign crc_next = msfr_pkg::crc16_byte(crc_base, i_rx_byte);
    assign crc_got  = {i_rx_byte, r_crc_lo};

    always_comb begin
        n_step      = r_step;
        n_position  = r_position;
        n_remaining = r_remaining;
        n_func      = r_func;
        n_third     = r_third;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        n_station   = r_station;
        n_learned   = r_learned;
        store       = 1'b0;
        go_idle     = 1'b0;
        complete    = 1'b0;
        o_result    = '0;
        o_result.event_res = msfr_pkg::EV_PROGRESS;

        unique case (r_step)
            S_IDLE: begin
                if (i_rx_byte == r_station) begin
                    store = 1'b1;
                end else if (!r_learned) begin
                    n_station          = i_rx_byte;
                    n_learned          = 1'b1;
                    o_result.event_res = msfr_pkg::EV_LEARNED;
                    go_idle            = 1'b1;
                end else begin
                    o_result.event_res = msfr_pkg::EV_DISCARDED;
                    go_idle            = 1'b1;
                end
            end
            S_FUNC: begin
                if (i_rx_byte == msfr_pkg::FC_READ || i_rx_byte == msfr_pkg::FC_WRITE ||
                    i_rx_byte == msfr_pkg::FC_EXCEPT || i_rx_byte == msfr_pkg::FC_SET_ADDR) begin
                    store = 1'b1;
                end else begin
                    o_result.event_res = msfr_pkg::EV_DISCARDED;
                    go_idle            = 1'b1;
                end
            end
            S_THIRD, S_B3, S_B4, S_B5, S_CRC_LO, S_CRC_HI, S_COUNT: begin
                store = 1'b1;
            end
            default: begin
                o_result.event_res = msfr_pkg::EV_DISCARDED;
                go_idle            = 1'b1;
            end
        endcase

        // frame would run past the buffer
        if (store && (r_position >= 8'(msfr_pkg::FRAME_CAP))) begin
            o_result.event_res = msfr_pkg::EV_OVERFLOW;
            go_idle            = 1'b1;
            store              = 1'b0;
        end

        if (store) begin
            o_result.byte_stored   = 1'b1;
            o_result.byte_position = r_position;
            o_result.byte_value    = i_rx_byte;
            n_position             = r_position + 8'd1;
            unique case (r_step)
                S_IDLE: begin
                    n_crc  = crc_next;
                    n_step = S_FUNC;
                end
                S_FUNC: begin
                    n_crc  = crc_next;
                    n_func = i_rx_byte;
                    n_step = S_THIRD;
                end
                S_THIRD: begin
                    n_crc   = crc_next;
                    n_third = i_rx_byte;
                    if (r_func == msfr_pkg::FC_READ) begin
                        n_remaining = i_rx_byte;
                        n_step      = S_COUNT;
                    end else if (r_func == msfr_pkg::FC_WRITE) begin
                        n_step = S_B3;
                    end else begin
                        n_step = S_CRC_LO;
                    end
                end
                S_B3: begin
                    n_crc  = crc_next;
                    n_step = S_B4;
                end
                S_B4: begin
                    n_crc  = crc_next;
                    n_step = S_B5;
                end
                S_B5: begin
                    n_crc  = crc_next;
                    n_step = S_CRC_LO;
                end
                S_COUNT: begin
                    n_crc = crc_next;
                    if (r_remaining <= 8'd1) begin
                        n_step = S_CRC_LO;
                    end else begin
                        n_remaining = r_remaining - 8'd1;
                    end
                end
                S_CRC_LO: begin
                    n_crc_lo = i_rx_byte;
                    n_step   = S_CRC_HI;
                end
                S_CRC_HI: begin
                    complete              = 1'b1;
                    o_result.frame_length = r_position + 8'd1;
                    if (crc_got != r_crc) begin
                        o_result.event_res = msfr_pkg::EV_CRC_BAD;
                    end else if (r_func == msfr_pkg::FC_SET_ADDR) begin
                        n_station          = r_third;
                        o_result.event_res = msfr_pkg::EV_ADDR_CHANGED;
                    end else begin
                        o_result.event_res = msfr_pkg::EV_OK;
                    end
                    o_result.turnaround = (r_func != msfr_pkg::FC_SET_ADDR);
                    go_idle             = 1'b1;
                end
                default: begin
                    go_idle = 1'b1;
                end
            endcase
        end

        if (go_idle) begin
            n_step     = S_IDLE;
            n_position = 8'd0;
        end

        o_result.station_address = n_station;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_position  <= 8'd0;
            r_remaining <= 8'd0;
            r_func      <= 8'd0;
            r_third     <= 8'd0;
            r_crc       <= msfr_pkg::CRC_INIT;
            r_crc_lo    <= 8'd0;
            r_station   <= msfr_pkg::RESET_STATION;
            r_learned   <= 1'b0;
        end else if (i_cfg_we) begin
            r_station <= i_cfg_wdata;
        end else if (i_accept) begin
            r_step      <= n_step;
            r_position  <= n_position;
            r_remaining <= n_remaining;
            r_func      <= n_func;
            r_third     <= n_third;
            r_crc       <= n_crc;
            r_crc_lo    <= n_crc_lo;
            r_station   <= n_station;
            r_learned   <= n_learned;
        end
    end

    `MSFR_ASSERT(a_idle_pos_zero, r_step == S_IDLE, r_position == 8'd0, "idle with open frame")
    `MSFR_ASSERT(a_busy_pos_set, r_step != S_IDLE, r_position != 8'd0, "frame open at position zero")
    `MSFR_ASSERT(a_complete_len, i_accept && complete,
        o_result.frame_length != 8'd0 && o_result.byte_stored, "completed frame without length")

endmodule

>>> src/modbus_style_frame_receiver.sv
// -----------------------------------------------------------------------------
// modbus_style_frame_receiver
// byte-wise modbus-style frame parser with crc-16 check and address learning
// -----------------------------------------------------------------------------
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+---------------------------
//  rx       | in        | i_rx_valid / o_rx_stall    | i_rx_byte
//  res      | out       | o_res_valid / i_res_stall  | event, byte echo, length,
//           |           |                            | turnaround, station
//  cfg      | in        | i_cfg_we (no wait)         | i_cfg_wdata (initial station)
//
//  one word per cycle unless rx is stalled: each rx word is decoded and the parse state
//  updated in the cycle it is accepted; its result is registered in the result register,
//  or in the skid slot while res is stalled; synchronous active-low reset clears the parse
//  state and loads station 1; a two-deep output stage (result register plus skid)
//  keeps rx flowing while res is stalled; rx stalls only once both are full
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "modbus_style_frame_receiver_macros.svh"

module modbus_style_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // received bytes
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    // results
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [2:0] o_event_res,
    output logic       o_byte_stored,
    output logic [7:0] o_byte_position,
    output logic [7:0] o_byte_value,
    output logic [7:0] o_frame_length,
    output logic       o_turnaround,
    output logic [7:0] o_station_address
);

    logic              rx_accept;
    logic              out_take;
    logic              out_free;
    msfr_pkg::t_result result;

    logic              r_out_valid,  n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    msfr_pkg::t_result r_out,        n_out;
    msfr_pkg::t_result r_skid,       n_skid;

    // rx is held off only when the skid slot is occupied
    assign o_rx_stall = r_skid_valid;
    assign rx_accept  = i_rx_valid & ~r_skid_valid;
    assign out_take   = r_out_valid & ~i_res_stall;
    assign out_free   = ~r_out_valid | out_take;

    msfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx_byte),
        .o_result    (result)
    );

    // output register and skid slot steering
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                // drain the skid word first, rx is stalled this cycle
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (rx_accept) begin
                n_out       = result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (rx_accept) begin
            // result register held by a stalled consumer, park in skid
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload words carry no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res_valid       = r_out_valid;
    assign o_event_res       = r_out.event_res;
    assign o_byte_stored     = r_out.byte_stored;
    assign o_byte_position   = r_out.byte_position;
    assign o_byte_value      = r_out.byte_value;
    assign o_frame_length    = r_out.frame_length;
    assign o_turnaround      = r_out.turnaround;
    assign o_station_address = r_out.station_address;

    `MSFR_ASSERT(a_skid_behind_out, r_skid_valid, r_out_valid, "skid word without output word")
    `MSFR_ASSERT_NEXT(a_skid_fills, r_out_valid && i_res_stall && !r_skid_valid && i_rx_valid,
        r_skid_valid, "accepted word lost while output stalled")
    `MSFR_ASSERT(a_turn_has_len, o_res_valid && o_turnaround,
        o_frame_length != 8'd0, "turnaround without frame length")

endmodule

>>> test/tb.sv
// -----------------------------------------------------------------------------
// tb
// self-checking bench for the modbus-style frame receiver
// -----------------------------------------------------------------------------
//  a short table of hand-picked bytes walks through address learning, foreign
//  and unknown bytes, and one frame of each function code
//  seven station settings follow, each with mostly well-formed frames carrying
//  random content plus noise, cut-off frames and bad crcs; two settings add a long
//  frame each (the largest frame that fits and one that overflows)
//  an in-bench parser tracks the frame state and computes every result word;
//  words are compared field by field in arrival order
//  both sides idle at random; two settings run with no idling, one of them
//  with a long receiver hold-off that fills the output stage
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int N_PHASES        = 7;
    localparam int WORDS_PER_PHASE = 20;
    localparam int LONG_HOLD       = 60;
    localparam int N_DIRECTED      = 28;

    // parser steps of the bench model
    typedef enum logic [3:0] {
        PS_ADDR   = 4'd0,
        PS_FUNC   = 4'd1,
        PS_BODY   = 4'd2,
        PS_WR1    = 4'd3,
        PS_WR2    = 4'd4,
        PS_WR3    = 4'd5,
        PS_CRC_LO = 4'd6,
        PS_CRC_HI = 4'd7,
        PS_DATA   = 4'd10
    } t_parse_step;

    // how a planned byte gets its value when it is put on the wire
    typedef enum logic [2:0] {
        BK_LIT,
        BK_CRC_LO,
        BK_CRC_HI,
        BK_CRC_LO_BAD,
        BK_CRC_HI_BAD
    } t_byte_kind;

    typedef struct packed {
        t_byte_kind kind;
        logic [7:0] data;   // literal byte, or xor mask for a corrupted crc byte
    } t_plan;

    typedef struct packed {
        t_plan             word;
        logic              typed;     // 1 when the result below is given by hand
        msfr_pkg::t_result want;
    } t_dir_row;

    localparam msfr_pkg::t_result NO_VALUE = '0;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       i_rx_valid;
    logic       o_rx_stall;
    logic [7:0] i_rx_byte;
    logic       o_res_valid;
    logic       i_res_stall;
    logic [2:0] o_event_res;
    logic       o_byte_stored;
    logic [7:0] o_byte_position;
    logic [7:0] o_byte_value;
    logic [7:0] o_frame_length;
    logic       o_turnaround;
    logic [7:0] o_station_address;

    modbus_style_frame_receiver dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_event_res       (o_event_res),
        .o_byte_stored     (o_byte_stored),
        .o_byte_position   (o_byte_position),
        .o_byte_value      (o_byte_value),
        .o_frame_length    (o_frame_length),
        .o_turnaround      (o_turnaround),
        .o_station_address (o_station_address)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state of the bench, updated once per accepted rx word
    t_parse_step rx_step;
    logic [7:0]  rx_pos;
    logic [7:0]  rx_left;
    logic [7:0]  rx_func;
    logic [7:0]  rx_body0;
    logic [15:0] rx_crc;
    logic [7:0]  rx_crc_lo;
    logic [7:0]  rx_station;
    logic        rx_learned;

    msfr_pkg::t_result results_due[$];
    t_plan             byte_plan[$];

    int      rx_count;
    int      res_count;
    int      mismatch_count;
    int      cycle_count;
    int      rx_stall_cycles;
    int      ev_tally[0:7];

    // shared between the rx driver, the res side and the monitor
    logic              quiet_gaps;
    logic              long_hold_req;
    logic              cur_typed;
    msfr_pkg::t_result cur_want;

    // hand-written walk: learning, foreign and unknown bytes, then one frame
    // per function code, a read with count zero and a bad crc among them
    t_dir_row directed_rows [N_DIRECTED] = '{
        // station 1 matches, frame starts
        '{'{BK_LIT, 8'h01}, 1'b1,
          '{msfr_pkg::EV_PROGRESS, 1'b1, 8'd0, 8'h01, 8'd0, 1'b0, 8'h01}},
        // not a function code
        '{'{BK_LIT, 8'h33}, 1'b1,
          '{msfr_pkg::EV_DISCARDED, 1'b0, 8'd0, 8'h00, 8'd0, 1'b0, 8'h01}},
        // first other address is learned
        '{'{BK_LIT, 8'h00}, 1'b1,
          '{msfr_pkg::EV_LEARNED, 1'b0, 8'd0, 8'h00, 8'd0, 1'b0, 8'h00}},
        // after learning a foreign address is dropped
        '{'{BK_LIT, 8'hFF}, 1'b1,
          '{msfr_pkg::EV_DISCARDED, 1'b0, 8'd0, 8'h00, 8'd0, 1'b0, 8'h00}},
        // write frame, four body bytes
        '{'{BK_LIT, 8'h00}, 1'b1,
          '{msfr_pkg::EV_PROGRESS, 1'b1, 8'd0, 8'h00, 8'd0, 1'b0, 8'h00}},
        '{'{BK_LIT, msfr_pkg::FC_WRITE}, 1'b1,
          '{msfr_pkg::EV_PROGRESS, 1'b1, 8'd1, msfr_pkg::FC_WRITE, 8'd0, 1'b0, 8'h00}},
        '{'{BK_LIT, 8'hFF}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'hAA}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'h55}, 1'b0, NO_VALUE},
        '{'{BK_CRC_LO, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_CRC_HI, 8'h00}, 1'b0, NO_VALUE},
        // exception frame with a broken crc high byte
        '{'{BK_LIT, 8'h00}, 1'b1,
          '{msfr_pkg::EV_PROGRESS, 1'b1, 8'd0, 8'h00, 8'd0, 1'b0, 8'h00}},
        '{'{BK_LIT, msfr_pkg::FC_EXCEPT}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'h80}, 1'b0, NO_VALUE},
        '{'{BK_CRC_LO, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_CRC_HI_BAD, 8'h01}, 1'b0, NO_VALUE},
        // read with count zero still takes one data byte
        '{'{BK_LIT, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_LIT, msfr_pkg::FC_READ}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'hFF}, 1'b0, NO_VALUE},
        '{'{BK_CRC_LO, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_CRC_HI, 8'h00}, 1'b0, NO_VALUE},
        // set-address frame moves the station to 0xfe
        '{'{BK_LIT, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_LIT, msfr_pkg::FC_SET_ADDR}, 1'b0, NO_VALUE},
        '{'{BK_LIT, 8'hFE}, 1'b0, NO_VALUE},
        '{'{BK_CRC_LO, 8'h00}, 1'b0, NO_VALUE},
        '{'{BK_CRC_HI, 8'h00}, 1'b0, NO_VALUE}
    };

    // modbus crc-16, reflected, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) acc = acc[0] ? ((acc >> 1) ^ msfr_pkg::CRC_POLY) : (acc >> 1);
        return acc;
    endfunction

    // feeds one received byte through the bench parser, returns its result word
    function automatic msfr_pkg::t_result parse_byte(input logic [7:0] b);
        msfr_pkg::t_result r;
        logic              keep;
        logic              done;
        r = '0;
        r.event_res = msfr_pkg::EV_PROGRESS;
        keep = 1'b0;
        done = 1'b0;
        case (rx_step)
            PS_ADDR: begin
                if (b == rx_station) begin
                    rx_crc = msfr_pkg::CRC_INIT;
                    rx_pos = 8'd0;
                    keep = 1'b1;
                end else if (!rx_learned) begin
                    rx_station = b;
                    rx_learned = 1'b1;
                    r.event_res = msfr_pkg::EV_LEARNED;
                    rx_pos = 8'd0;
                end else begin
                    r.event_res = msfr_pkg::EV_DISCARDED;
                    rx_pos = 8'd0;
                end
            end
            PS_FUNC: begin
                if (b == msfr_pkg::FC_READ || b == msfr_pkg::FC_WRITE ||
                    b == msfr_pkg::FC_EXCEPT || b == msfr_pkg::FC_SET_ADDR) begin
                    keep = 1'b1;
                end else begin
                    r.event_res = msfr_pkg::EV_DISCARDED;
                    rx_step = PS_ADDR;
                    rx_pos = 8'd0;
                end
            end
            PS_BODY, PS_WR1, PS_WR2, PS_WR3, PS_CRC_LO, PS_CRC_HI, PS_DATA: keep = 1'b1;
            default: begin
                r.event_res = msfr_pkg::EV_DISCARDED;
                rx_step = PS_ADDR;
                rx_pos = 8'd0;
            end
        endcase

        // frame would run past the buffer
        if (keep && rx_pos >= msfr_pkg::FRAME_CAP) begin
            r.event_res = msfr_pkg::EV_OVERFLOW;
            rx_step = PS_ADDR;
            rx_pos = 8'd0;
            keep = 1'b0;
        end

        if (keep) begin
            r.byte_stored = 1'b1;
            r.byte_position = rx_pos;
            r.byte_value = b;
            if (rx_step != PS_CRC_LO && rx_step != PS_CRC_HI) begin
                rx_crc = crc_step(rx_crc, b);
            end
            case (rx_step)
                PS_ADDR: rx_step = PS_FUNC;
                PS_FUNC: begin
                    rx_func = b;
                    rx_step = PS_BODY;
                end
                PS_BODY: begin
                    rx_body0 = b;
                    if (rx_func == msfr_pkg::FC_READ) begin
                        rx_left = b;
                        rx_step = PS_DATA;
                    end else if (rx_func == msfr_pkg::FC_WRITE) begin
                        rx_step = PS_WR1;
                    end else begin
                        rx_step = PS_CRC_LO;
                    end
                end
                PS_WR1: rx_step = PS_WR2;
                PS_WR2: rx_step = PS_WR3;
                PS_WR3: rx_step = PS_CRC_LO;
                PS_DATA: begin
                    if (rx_left <= 8'd1) begin
                        rx_step = PS_CRC_LO;
                    end else begin
                        rx_left = rx_left - 8'd1;
                    end
                end
                PS_CRC_LO: begin
                    rx_crc_lo = b;
                    rx_step = PS_CRC_HI;
                end
                default: begin
                    // crc high byte closes the frame
                    done = 1'b1;
                    r.frame_length = rx_pos + 8'd1;
                    if ({b, rx_crc_lo} != rx_crc) begin
                        r.event_res = msfr_pkg::EV_CRC_BAD;
                    end else if (rx_func == msfr_pkg::FC_SET_ADDR) begin
                        rx_station = rx_body0;
                        r.event_res = msfr_pkg::EV_ADDR_CHANGED;
                    end else begin
                        r.event_res = msfr_pkg::EV_OK;
                    end
                    r.turnaround = (rx_func != msfr_pkg::FC_SET_ADDR);
                    rx_step = PS_ADDR;
                    rx_pos = 8'd0;
                end
            endcase
            if (!done) begin
                rx_pos = rx_pos + 8'd1;
            end
        end
        r.station_address = rx_station;
        return r;
    endfunction

    // crc bytes take their value from the parser state at the time they are sent
    function automatic logic [7:0] wire_byte(input t_plan w);
        case (w.kind)
            BK_CRC_LO:     return rx_crc[7:0];
            BK_CRC_HI:     return rx_crc[15:8];
            BK_CRC_LO_BAD: return rx_crc[7:0] ^ w.data;
            BK_CRC_HI_BAD: return rx_crc[15:8] ^ w.data;
            default:       return w.data;
        endcase
    endfunction

    function automatic t_plan plan_word(input t_byte_kind kind, input logic [7:0] data);
        t_plan w;
        w.kind = kind;
        w.data = data;
        return w;
    endfunction

    // one frame to the current station, cut down to keep_len words if shorter
    function automatic void plan_frame(input logic [7:0] func, input logic [7:0] count,
                                       input int keep_len);
        t_plan f[$];
        int    n;
        int    crc_pick;
        f.push_back(plan_word(BK_LIT, rx_station));
        f.push_back(plan_word(BK_LIT, func));
        if (func == msfr_pkg::FC_READ) begin
            f.push_back(plan_word(BK_LIT, count));
            n = (count <= 8'd1) ? 1 : int'(count);
        end else if (func == msfr_pkg::FC_WRITE) begin
            n = 4;
        end else begin
            n = 1;
        end
        repeat (n) f.push_back(plan_word(BK_LIT, 8'($urandom)));
        crc_pick = $urandom_range(0, 9);
        if (crc_pick == 0) begin
            f.push_back(plan_word(BK_CRC_LO_BAD, 8'($urandom_range(1, 255))));
            f.push_back(plan_word(BK_CRC_HI, 8'h00));
        end else if (crc_pick == 1) begin
            f.push_back(plan_word(BK_CRC_LO, 8'h00));
            f.push_back(plan_word(BK_CRC_HI_BAD, 8'($urandom_range(1, 255))));
        end else begin
            f.push_back(plan_word(BK_CRC_LO, 8'h00));
            f.push_back(plan_word(BK_CRC_HI, 8'h00));
        end
        while (f.size() > keep_len) void'(f.pop_back());
        foreach (f[i]) byte_plan.push_back(f[i]);
    endfunction

    // next unit of random traffic: mostly clean frames, some noise and breakage
    function automatic void plan_traffic();
        int         pick;
        logic [7:0] func;
        logic [7:0] count;
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       func = msfr_pkg::FC_READ;
            1:       func = msfr_pkg::FC_WRITE;
            2:       func = msfr_pkg::FC_EXCEPT;
            default: func = msfr_pkg::FC_SET_ADDR;
        endcase
        count = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(7, 40))
                                            : 8'($urandom_range(0, 6));
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            plan_frame(func, count, 1000);
        end else if (pick < 75) begin
            // frame cut off early, the next bytes land in its body
            plan_frame(func, count, $urandom_range(1, 4));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 3)) byte_plan.push_back(plan_word(BK_LIT, 8'($urandom)));
        end else if (pick < 92) begin
            b = rx_station ^ 8'($urandom_range(1, 255));
            byte_plan.push_back(plan_word(BK_LIT, b));
        end else begin
            do b = 8'($urandom);
            while (b == msfr_pkg::FC_READ || b == msfr_pkg::FC_WRITE ||
                   b == msfr_pkg::FC_EXCEPT || b == msfr_pkg::FC_SET_ADDR);
            byte_plan.push_back(plan_word(BK_LIT, rx_station));
            byte_plan.push_back(plan_word(BK_LIT, b));
        end
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: res words are checked before the rx word of the same edge is
    // added, since a result never comes out in the cycle its byte goes in
    always @(posedge i_clk) begin : monitor
        msfr_pkg::t_result got;
        msfr_pkg::t_result want;
        msfr_pkg::t_result calc;
        cycle_count++;
        if (i_rst_n) begin
            if (o_res_valid && !i_res_stall) begin
                res_count++;
                got = {o_event_res, o_byte_stored, o_byte_position, o_byte_value,
                       o_frame_length, o_turnaround, o_station_address};
                if (!$isunknown(got.event_res)) begin
                    ev_tally[got.event_res]++;
                end
                if (results_due.size() == 0) begin
                    $error("result word with nothing outstanding: event %0d", got.event_res);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("event_res", want.event_res, got.event_res);
                    check_field("byte_stored", want.byte_stored, got.byte_stored);
                    check_field("byte_position", want.byte_position, got.byte_position);
                    check_field("byte_value", want.byte_value, got.byte_value);
                    check_field("frame_length", want.frame_length, got.frame_length);
                    check_field("turnaround", want.turnaround, got.turnaround);
                    check_field("station_address", want.station_address, got.station_address);
                end
            end
            if (i_rx_valid && !o_rx_stall) begin
                calc = parse_byte(i_rx_byte);
                results_due.push_back(cur_typed ? cur_want : calc);
                rx_count++;
            end
            if (i_rx_valid && o_rx_stall) begin
                rx_stall_cycles++;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // res side: a fresh stall count after every accepted word, or one long hold
    initial begin : res_side
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (res_count != seen) begin
                seen = res_count;
                hold = quiet_gaps ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0) begin
                i_res_stall <= 1'b1;
                hold--;
            end else begin
                i_res_stall <= 1'b0;
            end
        end
    end

    // puts one rx word out after a random gap and returns at the falling edge
    // after it was taken; a zero gap keeps valid high with the next byte
    task automatic send_word(input t_plan w, input logic typed, input msfr_pkg::t_result want);
        int gap;
        int seen;
        gap = quiet_gaps ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_typed = typed;
        cur_want = want;
        i_rx_valid <= 1'b1;
        i_rx_byte <= wire_byte(w);
        seen = rx_count;
        do @(negedge i_clk);
        while (rx_count == seen);
    endtask

    task automatic load_station(input logic [7:0] value);
        i_cfg_wdata <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rx_station = value;
    endtask

    initial begin : stimulus
        int sent;
        int goal;
        int drain;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'h00;
        i_rx_valid = 1'b0;
        i_rx_byte = 8'h00;
        i_res_stall = 1'b0;
        quiet_gaps = 1'b0;
        long_hold_req = 1'b0;
        cur_typed = 1'b0;
        cur_want = NO_VALUE;
        rx_count = 0;
        res_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        rx_stall_cycles = 0;
        foreach (ev_tally[i]) ev_tally[i] = 0;
        rx_step = PS_ADDR;
        rx_pos = 8'd0;
        rx_left = 8'd0;
        rx_func = 8'd0;
        rx_body0 = 8'd0;
        rx_crc = msfr_pkg::CRC_INIT;
        rx_crc_lo = 8'd0;
        rx_station = msfr_pkg::RESET_STATION;
        rx_learned = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at the reset station
        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].want);
        end
        i_rx_valid <= 1'b0;

        // random traffic, one station setting per phase
        for (int ph = 0; ph < N_PHASES; ph++) begin
            while (results_due.size() != 0) @(negedge i_clk);
            repeat (2) @(negedge i_clk);
            case (ph)
                0:       load_station(8'h00);
                1:       load_station(8'hFF);
                3:       load_station(8'h01);
                default: load_station(8'($urandom));
            endcase
            // phases 1 and 2 run back to back; phase 2 also fills the output stage
            quiet_gaps = (ph == 1 || ph == 2);
            long_hold_req = (ph == 2);
            // largest frame that fits, then one byte too many
            if (ph == 1) begin
                plan_frame(msfr_pkg::FC_READ, 8'd250, 1000);
            end
            if (ph == 4) begin
                plan_frame(msfr_pkg::FC_READ, 8'd251, 1000);
            end
            goal = WORDS_PER_PHASE + byte_plan.size();
            sent = 0;
            while (sent < goal || byte_plan.size() != 0) begin
                if (byte_plan.size() == 0) begin
                    plan_traffic();
                end
                send_word(byte_plan.pop_front(), 1'b0, NO_VALUE);
                sent++;
            end
            i_rx_valid <= 1'b0;
        end

        drain = 0;
        while (results_due.size() != 0 && drain < 2000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (8) @(negedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d result words never arrived", results_due.size());
            mismatch_count++;
        end

        $display("run: %0d bytes, %0d results checked, %0d stations, %0d cycles rx stalled",
                 rx_count, res_count, N_PHASES + 1, rx_stall_cycles);
        $display("events: %0d ok, %0d address changes, %0d crc bad, %0d discards, %0d overflows",
                 ev_tally[msfr_pkg::EV_OK], ev_tally[msfr_pkg::EV_ADDR_CHANGED],
                 ev_tally[msfr_pkg::EV_CRC_BAD], ev_tally[msfr_pkg::EV_DISCARDED],
                 ev_tally[msfr_pkg::EV_OVERFLOW]);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
